FILE: hw/rtl/ghe_pkg.sv
// shared constants and character table for the geohash encoder
`default_nettype none

package ghe_pkg;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int IDX_W   = 5;

    localparam logic [COUNT_W-1:0] CHAR_COUNT_RESET = 4'd8;

    // base32 geohash alphabet
    localparam logic [CHAR_W-1:0] ALPHABET [0:31] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
    };

endpackage

`default_nettype wire

FILE: hw/rtl/ghe_chan_if.sv
// handshake channel interfaces for coordinate pairs and hash characters
`default_nettype none

interface ghe_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ghe_pkg::COORD_W-1:0]   latitude;
    logic signed [ghe_pkg::COORD_W-1:0]   longitude;

    modport source (output valid, output latitude, output longitude, input ready);
    modport sink   (input valid, input latitude, input longitude, output ready);
endinterface

interface ghe_out_if;
    logic                          valid;
    logic                          ready;
    logic [ghe_pkg::CHAR_W-1:0]    hash_char;
    logic [ghe_pkg::IDX_W-1:0]     char_index;
    logic                          last_char;

    modport source (output valid, output hash_char, output char_index, output last_char,
                    input ready);
    modport sink   (input valid, input hash_char, input char_index, input last_char,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ghe_ser.sv
// character serialiser and output register of the geohash encoder
`default_nettype none

module ghe_ser #(
    parameter int CODE_W = 60
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [CODE_W-1:0]             i_code,
    input  wire logic [ghe_pkg::COUNT_W-1:0]   i_count,
    ghe_out_if.source                          o_hash
);

    logic                          r_valid;
    logic [ghe_pkg::CHAR_W-1:0]    r_char;
    logic [ghe_pkg::IDX_W-1:0]     r_idx;
    logic                          r_last;
    logic [CODE_W-1:0]             r_code;
    logic [ghe_pkg::COUNT_W-1:0]   r_left;

    logic                          advance;
    logic                          take;

    assign advance = !r_valid || o_hash.ready;
    assign take    = advance && (r_left == '0) && i_valid;
    assign o_ready = advance && (r_left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (advance) begin
            if (r_left != '0) begin
                r_valid <= 1'b1;
                r_left  <= ghe_pkg::COUNT_W'(r_left - 1'b1);
            end else if (i_valid) begin
                r_valid <= 1'b1;
                r_left  <= ghe_pkg::COUNT_W'(i_count - 1'b1);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload: next character from the held code or straight from upstream
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_left != '0) begin
                r_idx  <= r_code[CODE_W-1 -: ghe_pkg::IDX_W];
                r_char <= ghe_pkg::ALPHABET[r_code[CODE_W-1 -: ghe_pkg::IDX_W]];
                r_last <= (r_left == ghe_pkg::COUNT_W'(1));
                r_code <= r_code << ghe_pkg::IDX_W;
            end else if (i_valid) begin
                r_idx  <= i_code[CODE_W-1 -: ghe_pkg::IDX_W];
                r_char <= ghe_pkg::ALPHABET[i_code[CODE_W-1 -: ghe_pkg::IDX_W]];
                r_last <= (i_count == ghe_pkg::COUNT_W'(1));
                r_code <= i_code << ghe_pkg::IDX_W;
            end
        end
    end

    assign o_hash.valid      = r_valid;
    assign o_hash.hash_char  = r_char;
    assign o_hash.char_index = r_idx;
    assign o_hash.last_char  = r_last;

`ifndef SYNTHESIS
    a_left_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> r_valid)
        else $error("characters pending without a valid output");

    a_take_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_valid)
        else $error("accepted code did not reach the output register");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_left == '0))
        else $error("last character flagged with characters still pending");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/geohash_encoder_unit.sv
// top level of the geohash encoder: bisection pipeline and character output
// a coordinate pair is registered in stages 1, 2 and 3, then in the serialiser output
// one character per cycle while o_hash is ready, char_count (1 to MAX_CHARS) per pair
// the character serialiser sets the rate; the three coordinate stages stall behind it
// reset: synchronous active-low, clears valids and pending count, char_count returns to 8
`default_nettype none

module geohash_encoder_unit #(
    parameter int MAX_CHARS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ghe_pkg::COUNT_W-1:0]   i_cfg_wdata,
    ghe_in_if.sink                             i_coord,
    ghe_out_if.source                          o_hash
);

    localparam int CODE_W   = 5 * MAX_CHARS;
    localparam int LON_BITS = (CODE_W + 1) / 2;
    localparam int LAT_BITS = CODE_W / 2;
    localparam int CW       = ghe_pkg::COORD_W;

    logic [ghe_pkg::COUNT_W-1:0]   r_char_count;
    logic [ghe_pkg::COUNT_W-1:0]   n_count;

    // stage 1: offset coordinates
    logic                          r_s1_v;
    logic [CW-1:0]                 r_s1_lat;
    logic [CW-1:0]                 r_s1_lon;
    logic [ghe_pkg::COUNT_W-1:0]   r_s1_cnt;
    // stage 2: bisection bits per coordinate
    logic                          r_s2_v;
    logic [LAT_BITS-1:0]           r_s2_lat;
    logic [LON_BITS-1:0]           r_s2_lon;
    logic [ghe_pkg::COUNT_W-1:0]   r_s2_cnt;
    // stage 3: interleaved code
    logic                          r_s3_v;
    logic [CODE_W-1:0]             r_s3_code;
    logic [ghe_pkg::COUNT_W-1:0]   r_s3_cnt;

    logic                          s1_ready;
    logic                          s2_ready;
    logic                          s3_ready;
    logic                          ser_ready;

    logic [CW-1:0]                 n_lat_w;
    logic [CW-1:0]                 n_lon_w;
    logic [CODE_W-1:0]             n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= ghe_pkg::CHAR_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_char_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        priority if (r_char_count == '0) begin
            n_count = ghe_pkg::COUNT_W'(1);
        end else if (r_char_count > ghe_pkg::COUNT_W'(MAX_CHARS)) begin
            n_count = ghe_pkg::COUNT_W'(MAX_CHARS);
        end else begin
            n_count = r_char_count;
        end
    end

    assign s3_ready      = !r_s3_v || ser_ready;
    assign s2_ready      = !r_s2_v || s3_ready;
    assign s1_ready      = !r_s1_v || s2_ready;
    assign i_coord.ready = s1_ready;

    // strict greater-than bisection equals the binary digits of (offset - 1),
    // with offset zero giving all-zero digits
    always_comb begin
        n_lat_w = (r_s1_lat == '0) ? '0 : CW'(r_s1_lat - 1'b1);
        n_lon_w = (r_s1_lon == '0) ? '0 : CW'(r_s1_lon - 1'b1);
    end

    // longitude on even positions, latitude on odd, first bit most significant
    always_comb begin
        n_code = '0;
        for (int b = 0; b < CODE_W; b++) begin
            if ((b & 1) == 0) begin
                n_code[CODE_W-1-b] = r_s2_lon[LON_BITS-1-(b >> 1)];
            end else begin
                n_code[CODE_W-1-b] = r_s2_lat[LAT_BITS-1-(b >> 1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_coord.valid;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_ready) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_coord.valid) begin
            r_s1_lat <= {~i_coord.latitude[CW-1], i_coord.latitude[CW-2:0]};
            r_s1_lon <= {~i_coord.longitude[CW-1], i_coord.longitude[CW-2:0]};
            r_s1_cnt <= n_count;
        end
        if (s2_ready && r_s1_v) begin
            r_s2_lat <= n_lat_w[CW-1 -: LAT_BITS];
            r_s2_lon <= n_lon_w[CW-1 -: LON_BITS];
            r_s2_cnt <= r_s1_cnt;
        end
        if (s3_ready && r_s2_v) begin
            r_s3_code <= n_code;
            r_s3_cnt  <= r_s2_cnt;
        end
    end

    ghe_ser #(
        .CODE_W (CODE_W)
    ) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .o_ready (ser_ready),
        .i_code  (r_s3_code),
        .i_count (r_s3_cnt),
        .o_hash  (o_hash)
    );

`ifndef SYNTHESIS
    a_s3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && !ser_ready) |=> r_s3_v)
        else $error("stalled transaction dropped from stage 3");

    a_s3_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> ((r_s3_cnt != '0) && (r_s3_cnt <= ghe_pkg::COUNT_W'(MAX_CHARS))))
        else $error("character count out of range in stage 3");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !s3_ready) |=> (r_s2_v && $stable(r_s2_lat) && $stable(r_s2_lon)))
        else $error("stalled transaction changed in stage 2");
`endif

endmodule

`default_nettype wire
